>>> hdl/sacl_pkg.sv
package sacl_pkg;

   localparam int ADDR_BITS    = 32;
   localparam int RSP_WAY_BITS = 2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;  // zero one line of the tag store
      logic load_req;    // capture the request word, read way 0
      logic scan;        // evaluate the way just read, read the next one
      logic finish;      // final write, load the response word
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic scan_last;
   } dp_sts_type;

endpackage

>>> hdl/sacl_ctrl.sv
module sacl_ctrl
   import sacl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the response slot is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/sacl_dp.sv
module sacl_dp
   import sacl_pkg::*;
#(
   parameter int CACHE_BYTES = 32768,
   parameter int LINE_BYTES  = 32,
   parameter int WAYS        = 4,
   parameter int AGE_BITS    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_sts_type              sts,
   input  logic                    req_action,
   input  logic [ADDR_BITS-1:0]    req_addr,
   input  logic                    req_make_dirty,
   output logic                    rsp_hit,
   output logic [RSP_WAY_BITS-1:0] rsp_way,
   output logic                    rsp_writeback,
   output logic [ADDR_BITS-1:0]    rsp_victim_addr
);

   localparam int NUM_LINES = CACHE_BYTES / LINE_BYTES;
   localparam int SET_WAYS  = (WAYS < NUM_LINES) ? WAYS : NUM_LINES;
   localparam int SETS      = NUM_LINES / SET_WAYS;
   localparam int OFF_BITS  = $clog2(LINE_BYTES);
   localparam int SET_BITS  = $clog2(SETS);
   localparam int WAY_BITS  = $clog2(SET_WAYS);
   localparam int LINE_BITS = $clog2(NUM_LINES);
   localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_W     = (WAY_BITS > 0) ? WAY_BITS : 1;
   localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
   localparam int ENT_W     = 2 + TAG_BITS + AGE_BITS;

   localparam logic [WAY_W-1:0]     LAST_WAY  = WAY_W'(SET_WAYS - 1);
   localparam logic [LINE_BITS-1:0] LAST_LINE = LINE_BITS'(NUM_LINES - 1);
   localparam logic [AGE_BITS-1:0]  AGE_MAX   = {AGE_BITS{1'b1}};

   function automatic logic [LINE_BITS-1:0] line_of(input logic [SET_W-1:0] set_idx,
                                                     input logic [WAY_W-1:0] way_idx);
      line_of = (LINE_BITS'(set_idx) << WAY_BITS) | LINE_BITS'(way_idx);
   endfunction

   // tag store, one entry per line: {valid, dirty, tag, age}
   logic [ENT_W-1:0] line_mem [NUM_LINES];
   logic [ENT_W-1:0] rd_data_ff;

   logic                 rd_en, wr_en;
   logic [LINE_BITS-1:0] rd_idx, wr_idx;
   logic [ENT_W-1:0]     wr_data;

   logic [LINE_BITS-1:0] clr_ff, clr_in;
   logic [WAY_W-1:0]     way_ff, way_in;

   logic                 act_ff, act_in;
   logic                 mk_dirty_ff, mk_dirty_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   logic                 hit_ff, hit_in;
   logic [WAY_W-1:0]     hit_way_ff, hit_way_in;
   logic                 inv_found_ff, inv_found_in;
   logic [WAY_W-1:0]     inv_way_ff, inv_way_in;
   logic [WAY_W-1:0]     best_way_ff, best_way_in;
   logic [AGE_BITS-1:0]  best_age_ff, best_age_in;
   logic                 best_dirty_ff, best_dirty_in;
   logic [TAG_BITS-1:0]  best_tag_ff, best_tag_in;

   logic                    rsp_hit_ff, rsp_hit_in;
   logic [RSP_WAY_BITS-1:0] rsp_way_ff, rsp_way_in;
   logic                    rsp_wb_ff, rsp_wb_in;
   logic [ADDR_BITS-1:0]    rsp_victim_ff, rsp_victim_in;

   logic [ADDR_BITS-1:0] req_line;
   logic [SET_W-1:0]     req_set;
   logic [TAG_BITS-1:0]  req_tag;

   logic                 ent_valid, ent_dirty, ent_match;
   logic [TAG_BITS-1:0]  ent_tag;
   logic [AGE_BITS-1:0]  ent_age, age_inc;
   logic [WAY_W-1:0]     alloc_way;
   logic                 alloc_wb;
   logic [ADDR_BITS-1:0] victim_line;

   // split the byte address
   assign req_line = req_addr >> OFF_BITS;
   assign req_set  = (SET_BITS == 0) ? '0 : req_line[SET_W-1:0];
   assign req_tag  = TAG_BITS'(req_line >> SET_BITS);

   assign ent_valid = rd_data_ff[ENT_W-1];
   assign ent_dirty = rd_data_ff[ENT_W-2];
   assign ent_tag   = rd_data_ff[AGE_BITS +: TAG_BITS];
   assign ent_age   = rd_data_ff[AGE_BITS-1:0];
   assign ent_match = ent_valid && (ent_tag == tag_ff);
   assign age_inc   = (ent_age == AGE_MAX) ? ent_age : ent_age + AGE_BITS'(1);

   assign alloc_way   = inv_found_ff ? inv_way_ff : best_way_ff;
   assign alloc_wb    = !inv_found_ff && best_dirty_ff;
   assign victim_line = (ADDR_BITS'(best_tag_ff) << SET_BITS) | ADDR_BITS'(set_ff);

   assign sts.clear_last = (clr_ff == LAST_LINE);
   assign sts.scan_last  = (way_ff == LAST_WAY);

   always_comb begin
      rd_en  = cmd.load_req || (cmd.scan && !sts.scan_last);
      rd_idx = cmd.load_req ? line_of(req_set, '0)
                            : line_of(set_ff, WAY_W'(way_ff + 1'b1));

      wr_en   = 1'b0;
      wr_idx  = clr_ff;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.scan && !act_ff) begin
         // age every way of the set, clear the age of a matching way
         wr_en   = 1'b1;
         wr_idx  = line_of(set_ff, way_ff);
         wr_data = {ent_valid, ent_dirty, ent_tag, ent_match ? '0 : age_inc};
      end else if (cmd.finish) begin
         if (act_ff) begin
            wr_en   = 1'b1;
            wr_idx  = line_of(set_ff, alloc_way);
            wr_data = {1'b1, 1'b0, tag_ff, {AGE_BITS{1'b0}}};
         end else if (hit_ff && mk_dirty_ff) begin
            wr_en   = 1'b1;
            wr_idx  = line_of(set_ff, hit_way_ff);
            wr_data = {1'b1, 1'b1, tag_ff, {AGE_BITS{1'b0}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_idx];
      end
      if (wr_en) begin
         line_mem[wr_idx] <= wr_data;
      end
   end

   always_comb begin
      clr_in        = cmd.clear_step ? LINE_BITS'(clr_ff + 1'b1) : clr_ff;
      way_in        = way_ff;
      act_in        = act_ff;
      mk_dirty_in   = mk_dirty_ff;
      set_in        = set_ff;
      tag_in        = tag_ff;
      hit_in        = hit_ff;
      hit_way_in    = hit_way_ff;
      inv_found_in  = inv_found_ff;
      inv_way_in    = inv_way_ff;
      best_way_in   = best_way_ff;
      best_age_in   = best_age_ff;
      best_dirty_in = best_dirty_ff;
      best_tag_in   = best_tag_ff;
      if (cmd.load_req) begin
         way_in       = '0;
         act_in       = req_action;
         mk_dirty_in  = req_make_dirty;
         set_in       = req_set;
         tag_in       = req_tag;
         hit_in       = 1'b0;
         hit_way_in   = '0;
         inv_found_in = 1'b0;
         inv_way_in   = '0;
      end else if (cmd.scan) begin
         if (!sts.scan_last) begin
            way_in = WAY_W'(way_ff + 1'b1);
         end
         // later ways overwrite, so the highest matching way is kept
         if (ent_match) begin
            hit_in     = 1'b1;
            hit_way_in = way_ff;
         end
         if (!ent_valid && !inv_found_ff) begin
            inv_found_in = 1'b1;
            inv_way_in   = way_ff;
         end
         // strict compare: the lowest way wins a tie
         if (way_ff == '0 || ent_age > best_age_ff) begin
            best_way_in   = way_ff;
            best_age_in   = ent_age;
            best_dirty_in = ent_dirty;
            best_tag_in   = ent_tag;
         end
      end
   end

   always_comb begin
      rsp_hit_in    = rsp_hit_ff;
      rsp_way_in    = rsp_way_ff;
      rsp_wb_in     = rsp_wb_ff;
      rsp_victim_in = rsp_victim_ff;
      if (cmd.finish) begin
         if (act_ff) begin
            rsp_hit_in    = 1'b1;
            rsp_way_in    = RSP_WAY_BITS'(alloc_way);
            rsp_wb_in     = alloc_wb;
            rsp_victim_in = alloc_wb ? (victim_line << OFF_BITS) : '0;
         end else begin
            rsp_hit_in    = hit_ff;
            rsp_way_in    = hit_ff ? RSP_WAY_BITS'(hit_way_ff) : '0;
            rsp_wb_in     = 1'b0;
            rsp_victim_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      way_ff        <= way_in;
      act_ff        <= act_in;
      mk_dirty_ff   <= mk_dirty_in;
      set_ff        <= set_in;
      tag_ff        <= tag_in;
      hit_ff        <= hit_in;
      hit_way_ff    <= hit_way_in;
      inv_found_ff  <= inv_found_in;
      inv_way_ff    <= inv_way_in;
      best_way_ff   <= best_way_in;
      best_age_ff   <= best_age_in;
      best_dirty_ff <= best_dirty_in;
      best_tag_ff   <= best_tag_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_wb_ff     <= rsp_wb_in;
      rsp_victim_ff <= rsp_victim_in;
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_way         = rsp_way_ff;
   assign rsp_writeback   = rsp_wb_ff;
   assign rsp_victim_addr = rsp_victim_ff;

endmodule

>>> hdl/set_assoc_cache_tags_lru.sv
// channel  | handshake            | word
// ---------+----------------------+---------------------------------------------
// req      | req_valid/req_stall  | req_action, req_addr, req_make_dirty
// rsp      | rsp_valid/rsp_stall  | rsp_hit, rsp_way, rsp_writeback,
//          |                      | rsp_victim_addr
//
// Each request steps through accepting the word and reading way 0, a scan of
// the ways one way at a time through the single read port of the tag store,
// and the final write and loading of the response register.
// After reset the tag store is zeroed one line a cycle, all CACHE_BYTES/LINE_BYTES
// lines (1024 by default); req_stall stays high meanwhile.
// A response waiting under rsp_stall does not block the next request; only its
// final step waits for the response register to free up.
//
// CACHE_BYTES, LINE_BYTES and WAYS must be powers of two; the block does not check it.
module set_assoc_cache_tags_lru
   import sacl_pkg::*;
#(
   parameter int CACHE_BYTES = 32768,
   parameter int LINE_BYTES  = 32,
   parameter int WAYS        = 4,
   parameter int AGE_BITS    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic [ADDR_BITS-1:0]    req_addr,
   input  logic                    req_make_dirty,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit,
   output logic [RSP_WAY_BITS-1:0] rsp_way,
   output logic                    rsp_writeback,
   output logic [ADDR_BITS-1:0]    rsp_victim_addr
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: clear pass, accept, way scan, finish
   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // tag store, per-way evaluation, response register
   sacl_dp #(
      .CACHE_BYTES (CACHE_BYTES),
      .LINE_BYTES  (LINE_BYTES),
      .WAYS        (WAYS),
      .AGE_BITS    (AGE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_addr        (req_addr),
      .req_make_dirty  (req_make_dirty),
      .rsp_hit         (rsp_hit),
      .rsp_way         (rsp_way),
      .rsp_writeback   (rsp_writeback),
      .rsp_victim_addr (rsp_victim_addr)
   );

endmodule

>>> hdl/sacl_chk.sv
module sacl_chk
   import sacl_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_hit,
   input logic [RSP_WAY_BITS-1:0] rsp_way,
   input logic                    rsp_writeback,
   input logic [ADDR_BITS-1:0]    rsp_victim_addr
);

   // no request is taken right after reset: the clear pass runs first
   a_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request side open right after reset");

   // one request at a time: an accept closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted back to back");

   // a writeback comes only from an allocate, which always reports hit
   a_wb_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_writeback) |-> rsp_hit)
      else $error("writeback without hit");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_writeback) |-> (rsp_victim_addr == '0))
      else $error("victim address without writeback");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_way)
                                    && $stable(rsp_victim_addr)))
      else $error("stalled response changed");

endmodule

bind set_assoc_cache_tags_lru sacl_chk u_sacl_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_way         (rsp_way),
   .rsp_writeback   (rsp_writeback),
   .rsp_victim_addr (rsp_victim_addr)
);
